// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/tpfc_pkg.sv -----
// Package for the touch point filter: types, codes, coefficient table.
package tpfc_pkg;

   localparam int SAMPLE_W           = 12;
   localparam int TOTAL_W            = 16;
   localparam int MODE_W             = 3;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 12;
   localparam int ADC_BITS_DEFAULT   = 12;
   localparam int COEF_FRAC_DEFAULT  = 20;
   localparam int BURST_LEN          = 10;
   localparam int TRIM_SHIFT         = 3;
   localparam int QUEUE_DEPTH        = 4;
   localparam int NUM_MODES          = 8;
   localparam int NUM_COEFS          = 6;
   localparam longint MICRO_SCALE    = 1000000;
   localparam longint MICRO_HALF     = 500000;

   localparam logic [CSR_DATA_W-1:0] SCREEN_WIDTH_RESET  = 12'd240;
   localparam logic [CSR_DATA_W-1:0] SCREEN_HEIGHT_RESET = 12'd320;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIENT_SEL    = 2'd0,
      CSR_SCREEN_WIDTH  = 2'd1,
      CSR_SCREEN_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_LIFTED  = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic {
      EVT_LIFTED = 1'b0,
      EVT_POINT  = 1'b1
   } event_kind_type;

   // coefficient slots within a row
   localparam int COEF_XX = 0;
   localparam int COEF_XY = 1;
   localparam int COEF_X0 = 2;
   localparam int COEF_YX = 3;
   localparam int COEF_YY = 4;
   localparam int COEF_Y0 = 5;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x_sample;
      logic [SAMPLE_W-1:0] y_sample;
      logic                pen_down;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] point_x;
      logic [SAMPLE_W-1:0] point_y;
      status_type          status;
   } rsp_payload_type;

   // burst summary handed from front to back
   typedef struct packed {
      event_kind_type      kind;
      logic [TOTAL_W-1:0]  x_total;
      logic [SAMPLE_W-1:0] x_low;
      logic [SAMPLE_W-1:0] x_high;
      logic [TOTAL_W-1:0]  y_total;
      logic [SAMPLE_W-1:0] y_low;
      logic [SAMPLE_W-1:0] y_high;
   } event_type;

   typedef struct packed {
      logic [MODE_W-1:0]     orient_sel;
      logic [CSR_DATA_W-1:0] screen_width;
      logic [CSR_DATA_W-1:0] screen_height;
   } cfg_type;

   typedef logic signed [NUM_MODES-1:0][NUM_COEFS-1:0][63:0] coef_table_type;

   // coefficients in millionths
   localparam longint CAL_MICRO [NUM_MODES][NUM_COEFS] = '{
      '{-6464,  -73259, 280358032,  74878,   2052,   -6545977},
      '{86314,    1891, -12836658,  -3722, -65799,  254715714},
      '{ 2782,   61522, -11595689,  83393,   5159,  -15650089},
      '{89743,    -289, -20612209,  -1374,  64451,  -16054003},
      '{  767,  -68258, 250891769, -85559,   -195,  334747650},
      '{-84744,     47, 323163147,  -2109, -66371,  260985809},
      '{-1848,   66984, -12807136, -84858,   -805,  333395386},
      '{-85470,   -876, 334023163,  -3390,  64725,   -6211169}
   };

   // fixed-point table, rounding halves away from zero
   function automatic coef_table_type fixed_table(int frac_bits);
      coef_table_type tbl;
      longint         mag;
      longint         q;
      tbl = '0;
      for (int m = 0; m < NUM_MODES; m++) begin
         for (int c = 0; c < NUM_COEFS; c++) begin
            mag = (CAL_MICRO[m][c] < 0) ? -CAL_MICRO[m][c] : CAL_MICRO[m][c];
            q   = ((mag <<< frac_bits) + MICRO_HALF) / MICRO_SCALE;
            tbl[m][c] = (CAL_MICRO[m][c] < 0) ? -q : q;
         end
      end
      return tbl;
   endfunction

endpackage

// ----- rtl/tpfc_front.sv -----
// Front end: takes sample requests, tracks burst extremes and sums, emits burst events.
module tpfc_front #(
   parameter int ADC_BITS = tpfc_pkg::ADC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tpfc_pkg::req_payload_type req_payload,
   input  logic                      queue_full,
   output logic                      push,
   output tpfc_pkg::event_type       push_event
);

   localparam int TOT_W = ADC_BITS + 4;
   localparam int TW    = tpfc_pkg::TOTAL_W;
   localparam int SW    = tpfc_pkg::SAMPLE_W;
   localparam logic [3:0] LAST_COUNT = 4'(tpfc_pkg::BURST_LEN - 1);

   logic [3:0]          count_ff, count_in;
   logic [ADC_BITS-1:0] x_low_ff, x_low_in, x_high_ff, x_high_in;
   logic [ADC_BITS-1:0] y_low_ff, y_low_in, y_high_ff, y_high_in;
   logic [TOT_W-1:0]    x_total_ff, x_total_in, y_total_ff, y_total_in;
   logic [ADC_BITS-1:0] xs, ys;
   logic                accept, first, last;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign xs        = req_payload.x_sample[ADC_BITS-1:0];
   assign ys        = req_payload.y_sample[ADC_BITS-1:0];
   assign first     = (count_ff == '0);
   assign last      = (count_ff >= LAST_COUNT);

   always_comb begin
      x_low_in   = (first || xs < x_low_ff)  ? xs : x_low_ff;
      x_high_in  = (first || xs > x_high_ff) ? xs : x_high_ff;
      y_low_in   = (first || ys < y_low_ff)  ? ys : y_low_ff;
      y_high_in  = (first || ys > y_high_ff) ? ys : y_high_ff;
      x_total_in = first ? TOT_W'(xs) : x_total_ff + TOT_W'(xs);
      y_total_in = first ? TOT_W'(ys) : y_total_ff + TOT_W'(ys);
      count_in   = (!req_payload.pen_down || last) ? 4'd0 : count_ff + 4'd1;
   end

   always_comb begin
      push               = accept && (!req_payload.pen_down || last);
      push_event.kind    = req_payload.pen_down ? tpfc_pkg::EVT_POINT : tpfc_pkg::EVT_LIFTED;
      push_event.x_total = TW'(x_total_in);
      push_event.y_total = TW'(y_total_in);
      push_event.x_low   = SW'(x_low_in);
      push_event.x_high  = SW'(x_high_in);
      push_event.y_low   = SW'(y_low_in);
      push_event.y_high  = SW'(y_high_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_low_ff   <= x_low_in;
         x_high_ff  <= x_high_in;
         y_low_ff   <= y_low_in;
         y_high_ff  <= y_high_in;
         x_total_ff <= x_total_in;
         y_total_ff <= y_total_in;
      end
   end

endmodule

// ----- rtl/tpfc_queue.sv -----
// Short event queue between front and back.
module tpfc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpfc_pkg::event_type push_event,
   input  logic                pop,
   output tpfc_pkg::event_type head,
   output logic                empty,
   output logic                full
);

   localparam int DEPTH = tpfc_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   tpfc_pkg::event_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

// ----- rtl/tpfc_back.sv -----
// Back end: trimmed mean, affine calibration pipeline, range check, response register.
module tpfc_back #(
   parameter int COEF_FRAC_BITS = tpfc_pkg::COEF_FRAC_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tpfc_pkg::cfg_type         cfg,
   input  tpfc_pkg::event_type       head,
   input  logic                      empty,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tpfc_pkg::rsp_payload_type rsp_payload
);

   localparam int F      = COEF_FRAC_BITS;
   localparam int RW     = tpfc_pkg::TOTAL_W - tpfc_pkg::TRIM_SHIFT;
   localparam int KW     = F + 1;
   localparam int PROD_W = KW + RW + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam int WW     = ACC_W - 1 - F;
   localparam int SW     = tpfc_pkg::SAMPLE_W;
   localparam tpfc_pkg::coef_table_type COEF_TABLE = tpfc_pkg::fixed_table(COEF_FRAC_BITS);

   logic advance;

   // stage 0: trimmed averages
   logic                     s0_valid_ff;
   tpfc_pkg::event_kind_type s0_kind_ff;
   logic [RW-1:0]            s0_rx_ff, s0_ry_ff;
   logic [tpfc_pkg::TOTAL_W-1:0] x_trim, y_trim;

   // stage 1: products
   logic                     s1_valid_ff;
   tpfc_pkg::event_kind_type s1_kind_ff;
   logic signed [PROD_W-1:0] p_xx_ff, p_xy_ff, p_yx_ff, p_yy_ff;
   logic signed [PROD_W-1:0] p_xx_in, p_xy_in, p_yx_in, p_yy_in;
   logic signed [KW-1:0]     c_xx, c_xy, c_yx, c_yy;
   logic signed [RW:0]       rx_s, ry_s;

   // stage 2: sums
   logic                     s2_valid_ff;
   tpfc_pkg::event_kind_type s2_kind_ff;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_y_ff, acc_x_in, acc_y_in;
   logic signed [ACC_W-1:0]  c_x0, c_y0;

   // output register
   logic                      rsp_valid_ff;
   tpfc_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [WW-1:0]             whole_x, whole_y;
   logic                      x_ok, y_ok;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign pop         = advance && !empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign x_trim = head.x_total - tpfc_pkg::TOTAL_W'(head.x_low) - tpfc_pkg::TOTAL_W'(head.x_high);
   assign y_trim = head.y_total - tpfc_pkg::TOTAL_W'(head.y_low) - tpfc_pkg::TOTAL_W'(head.y_high);

   always_comb begin
      c_xx = KW'($signed(COEF_TABLE[cfg.orient_sel][tpfc_pkg::COEF_XX]));
      c_xy = KW'($signed(COEF_TABLE[cfg.orient_sel][tpfc_pkg::COEF_XY]));
      c_yx = KW'($signed(COEF_TABLE[cfg.orient_sel][tpfc_pkg::COEF_YX]));
      c_yy = KW'($signed(COEF_TABLE[cfg.orient_sel][tpfc_pkg::COEF_YY]));
      c_x0 = ACC_W'($signed(COEF_TABLE[cfg.orient_sel][tpfc_pkg::COEF_X0]));
      c_y0 = ACC_W'($signed(COEF_TABLE[cfg.orient_sel][tpfc_pkg::COEF_Y0]));
      rx_s = $signed({1'b0, s0_rx_ff});
      ry_s = $signed({1'b0, s0_ry_ff});
      p_xx_in = PROD_W'(c_xx * rx_s);
      p_xy_in = PROD_W'(c_xy * ry_s);
      p_yx_in = PROD_W'(c_yx * rx_s);
      p_yy_in = PROD_W'(c_yy * ry_s);
      acc_x_in = ACC_W'(p_xx_ff) + ACC_W'(p_xy_ff) + c_x0;
      acc_y_in = ACC_W'(p_yx_ff) + ACC_W'(p_yy_ff) + c_y0;
   end

   always_comb begin
      whole_x = acc_x_ff[ACC_W-2:F];
      whole_y = acc_y_ff[ACC_W-2:F];
      x_ok = !acc_x_ff[ACC_W-1] && (whole_x < WW'(cfg.screen_width));
      y_ok = !acc_y_ff[ACC_W-1] && (whole_y < WW'(cfg.screen_height));
      rsp_payload_in = '0;
      if (s2_kind_ff == tpfc_pkg::EVT_LIFTED) begin
         rsp_payload_in.status = tpfc_pkg::STATUS_LIFTED;
      end else if (x_ok && y_ok) begin
         rsp_payload_in.point_x = SW'(whole_x);
         rsp_payload_in.point_y = SW'(whole_y);
         rsp_payload_in.status  = tpfc_pkg::STATUS_OK;
      end else begin
         rsp_payload_in.status = tpfc_pkg::STATUS_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= !empty;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_kind_ff     <= head.kind;
         s0_rx_ff       <= x_trim[tpfc_pkg::TOTAL_W-1:tpfc_pkg::TRIM_SHIFT];
         s0_ry_ff       <= y_trim[tpfc_pkg::TOTAL_W-1:tpfc_pkg::TRIM_SHIFT];
         s1_kind_ff     <= s0_kind_ff;
         p_xx_ff        <= p_xx_in;
         p_xy_ff        <= p_xy_in;
         p_yx_ff        <= p_yx_in;
         p_yy_ff        <= p_yy_in;
         s2_kind_ff     <= s1_kind_ff;
         acc_x_ff       <= acc_x_in;
         acc_y_ff       <= acc_y_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

// ----- rtl/touch_point_filter_calibrate.sv -----
// Touch point filter and calibration: top level with configuration registers.
// A request that ends a burst passes, after acceptance, through the event queue
// and then the trim, multiply, sum and response registers before its response shows.
// Throughput is one request per cycle; the 4-entry queue stalls requests only when full.
// Reset is synchronous and active high: burst count, queue, pipeline valids clear,
// orientation select returns to 0, screen size to 240 by 320.
module touch_point_filter_calibrate #(
   parameter int ADC_BITS       = tpfc_pkg::ADC_BITS_DEFAULT,
   parameter int COEF_FRAC_BITS = tpfc_pkg::COEF_FRAC_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tpfc_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tpfc_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [tpfc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tpfc_pkg::CSR_DATA_W-1:0]      csr_data
);

   tpfc_pkg::cfg_type   cfg_ff;
   tpfc_pkg::event_type push_event, head;
   logic                push, pop, empty, full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orient_sel    <= '0;
         cfg_ff.screen_width  <= tpfc_pkg::SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= tpfc_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            tpfc_pkg::CSR_ORIENT_SEL: begin
               cfg_ff.orient_sel <= csr_data[tpfc_pkg::MODE_W-1:0];
            end
            tpfc_pkg::CSR_SCREEN_WIDTH: begin
               cfg_ff.screen_width <= csr_data;
            end
            tpfc_pkg::CSR_SCREEN_HEIGHT: begin
               cfg_ff.screen_height <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   tpfc_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (full),
      .push        (push),
      .push_event  (push_event)
   );

   tpfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   tpfc_back #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/tpfc_checker.sv -----
// Port-level checker for the touch point filter, bound to the top level.
`include "assert_macros.svh"

module tpfc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input tpfc_pkg::rsp_payload_type rsp_payload
);

   logic rsp_not_ok;
   logic point_zero;

   assign rsp_not_ok = rsp_valid && (rsp_payload.status != tpfc_pkg::STATUS_OK);
   assign point_zero = (rsp_payload.point_x == '0) && (rsp_payload.point_y == '0);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `ASSERT_SAME(a_reject_zero, clock, reset, rsp_not_ok, point_zero)
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_stall)
   `ASSERT_NEXT(a_stall_release, clock, reset, req_stall && !rsp_stall, !req_stall)

endmodule

bind touch_point_filter_calibrate tpfc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
